@@ hw/rtl/aprs_pkg.sv @@
// shared types, codes and helpers for the ata pio read host sequencer
package aprs_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_DATA  = 2'd2,
        KIND_DONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_ERR     = 3'd2,
        ST_FAULT   = 3'd3,
        ST_NODEV   = 3'd4,
        ST_NOTATA  = 3'd5,
        ST_RANGE   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        MODE_IDENTIFY = 2'd0,
        MODE_READ     = 2'd1,
        MODE_REPLY    = 2'd2
    } mode_t;

    // configuration register indexes
    localparam logic [7:0] CFG_IO_BASE   = 8'd0;
    localparam logic [7:0] CFG_CTRL_BASE = 8'd1;
    localparam logic [7:0] CFG_SLAVE     = 8'd2;
    localparam logic [7:0] CFG_TIMEOUT   = 8'd3;

    localparam logic [15:0] IO_BASE_RESET   = 16'h01F0;
    localparam logic [15:0] CTRL_BASE_RESET = 16'h03F6;
    localparam logic [31:0] TIMEOUT_RESET   = 32'h0200_0000;

    // command block register offsets
    localparam logic [15:0] REG_DATA    = 16'd0;
    localparam logic [15:0] REG_COUNT   = 16'd2;
    localparam logic [15:0] REG_LBA_LO  = 16'd3;
    localparam logic [15:0] REG_LBA_MID = 16'd4;
    localparam logic [15:0] REG_LBA_HI  = 16'd5;
    localparam logic [15:0] REG_DEVICE  = 16'd6;
    localparam logic [15:0] REG_STATUS  = 16'd7;

    localparam logic [7:0] SEL_IDENTIFY = 8'hA0;
    localparam logic [7:0] SEL_LBA48    = 8'h40;
    localparam logic [7:0] SEL_LBA28    = 8'hE0;
    localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
    localparam logic [7:0] CMD_READ28   = 8'h20;
    localparam logic [7:0] CMD_READ48   = 8'h24;

    localparam logic [7:0] SR_BSY = 8'h80;
    localparam logic [7:0] SR_DF  = 8'h20;
    localparam logic [7:0] SR_DRQ = 8'h08;
    localparam logic [7:0] SR_ERR = 8'h01;

    localparam logic [48:0] LBA28_LAST  = 49'h0_0FFF_FFFF;
    localparam logic [48:0] LBA28_LIMIT = 49'h0_1000_0000;

    // write or data bursts that come before the final result of a word
    typedef enum logic [2:0] {
        SC_NONE   = 3'd0,
        SC_ID_SEL = 3'd1,
        SC_ID_CMD = 3'd2,
        SC_RD_SEL = 3'd3,
        SC_CMD28  = 3'd4,
        SC_CMD48  = 3'd5,
        SC_DATA   = 3'd6
    } script_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] lba;
        logic [31:0] count;
        logic [15:0] read_data;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] port_address;
        logic        access_wide;
        logic [7:0]  write_value;
        logic [15:0] data_word;
        logic [2:0]  status_code;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [15:0] io_base;
        logic [15:0] ctrl_base;
        logic        slave;
        logic [31:0] timeout;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] port;
        logic        wide;
        status_t     status;
    } tail_t;

    typedef struct packed {
        script_t     script;
        logic [7:0]  sel;
        logic [8:0]  chunk;
        logic [47:0] lba;
        logic [15:0] data;
        logic [15:0] io_base;
        tail_t       tail;
    } desc_t;

    function automatic tail_t tail_rd(logic [15:0] port, logic wide);
        tail_t t;
        t.kind   = KIND_READ;
        t.port   = port;
        t.wide   = wide;
        t.status = ST_OK;
        return t;
    endfunction

    function automatic tail_t tail_fin(status_t code);
        tail_t t;
        t.kind   = KIND_DONE;
        t.port   = 16'd0;
        t.wide   = 1'b0;
        t.status = code;
        return t;
    endfunction

    function automatic logic [3:0] script_len(script_t s);
        logic [3:0] n;
        case (s)
            SC_ID_SEL, SC_RD_SEL, SC_DATA: n = 4'd1;
            SC_ID_CMD, SC_CMD28:           n = 4'd5;
            SC_CMD48:                      n = 4'd9;
            default:                       n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

@@ hw/rtl/ata_pio_read_host_sequencer.sv @@
// top level of the ata pio read host sequencer
// Takes one request or reply word per cycle while its two-entry burst queue has room; each word
// advances the identify or read sequence at once and queues the results it causes. The back
// end drives one result word per cycle from the queue head while rsp_stall is low, so a word
// that causes n results (1 to 10, the most for an lba48 command burst) holds it until all are
// out; the result rate of the back end sets the sustained throughput. The last result of each
// word has last set. Configuration writes are always taken (cfg_ready is tied high) and are
// meant to be made while no operation is running.
module ata_pio_read_host_sequencer #(
    parameter int MAX_CHUNK_SECTORS = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  aprs_pkg::req_t req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output aprs_pkg::rsp_t rsp_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_index,
    input  logic [31:0]    cfg_data
);
    import aprs_pkg::*;

    cfg_t  cfg_reg;
    logic  q_full;
    logic  q_valid;
    logic  q_push;
    logic  q_pop;
    desc_t push_desc;
    desc_t head;
    logic  accept;

    assign cfg_ready = 1'b1;
    assign req_stall = q_full;
    assign accept    = req_valid && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.io_base   <= IO_BASE_RESET;
            cfg_reg.ctrl_base <= CTRL_BASE_RESET;
            cfg_reg.slave     <= 1'b0;
            cfg_reg.timeout   <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IO_BASE:   cfg_reg.io_base   <= cfg_data[15:0];
                CFG_CTRL_BASE: cfg_reg.ctrl_base <= cfg_data[15:0];
                CFG_SLAVE:     cfg_reg.slave     <= cfg_data[0];
                CFG_TIMEOUT:   cfg_reg.timeout   <= cfg_data;
                default: ;
            endcase
        end
    end

    aprs_front #(
        .MAX_CHUNK_SECTORS(MAX_CHUNK_SECTORS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (req_data),
        .cfg    (cfg_reg),
        .push   (q_push),
        .desc   (push_desc)
    );

    aprs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .pop       (q_pop),
        .full      (q_full),
        .valid     (q_valid),
        .head      (head)
    );

    aprs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head       (head),
        .pop        (q_pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_data   (rsp_data)
    );

    // a burst is only queued for a word that was really taken
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> accept)
        else $error("burst queued without an accepted word");

    // the back end only retires a burst that is present
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("burst retired from an empty queue");

    // retiring a burst always shows its final word on the output next
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (rsp_valid && rsp_data.last))
        else $error("retired burst did not end with a last word");

endmodule

@@ hw/rtl/aprs_front.sv @@
// front end: takes request and reply words, runs the sequence, queues result bursts
module aprs_front #(
    parameter int MAX_CHUNK_SECTORS = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  aprs_pkg::req_t item,
    input  aprs_pkg::cfg_t cfg,
    output logic           push,
    output aprs_pkg::desc_t desc
);
    import aprs_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ID_SEL_SETTLE, PH_ID_CMD_SETTLE, PH_ID_STATUS, PH_ID_NB,
        PH_ID_MID, PH_ID_HI, PH_ID_DRQ, PH_ID_DATA,
        PH_RD_NB, PH_RD_SETTLE, PH_RD_DRQ, PH_RD_DATA
    } phase_t;

    localparam logic [31:0] MAX_CHUNK = 32'(MAX_CHUNK_SECTORS);

    phase_t      phase_reg, phase_next;
    logic [31:0] spin_reg, spin_next;
    logic [47:0] lba_reg, lba_next;
    logic [31:0] rem_reg, rem_next;
    logic [8:0]  chunk_reg, chunk_next;
    logic [8:0]  left_reg, left_next;
    logic [7:0]  word_reg, word_next;
    logic [1:0]  settle_reg, settle_next;
    logic        present_reg, present_next;
    logic        lba48_reg, lba48_next;
    logic [31:0] cap28_reg, cap28_next;
    logic [63:0] cap_reg, cap_next;
    logic [63:0] ext_reg, ext_next;

    logic [7:0]  b;
    logic [32:0] spin_inc;
    logic        poll_to;
    logic        wait_fin;
    logic [48:0] lba_end;
    logic        use48;
    logic        range28;
    logic        settle_done;
    logic [31:0] rem_after;
    logic [8:0]  left_after;
    logic [48:0] req_end;
    logic [7:0]  slave_bit;
    logic [15:0] port_status;
    logic [15:0] port_ctrl;
    logic [15:0] port_data;
    logic [7:0]  status_b;

    always_comb
    begin
        phase_next   = phase_reg;
        spin_next    = spin_reg;
        lba_next     = lba_reg;
        rem_next     = rem_reg;
        chunk_next   = chunk_reg;
        left_next    = left_reg;
        word_next    = word_reg;
        settle_next  = settle_reg;
        present_next = present_reg;
        lba48_next   = lba48_reg;
        cap28_next   = cap28_reg;
        cap_next     = cap_reg;
        ext_next     = ext_reg;

        b           = item.read_data[7:0];
        slave_bit   = {3'b000, cfg.slave, 4'b0000};
        port_status = cfg.io_base + REG_STATUS;
        port_data   = cfg.io_base + REG_DATA;
        port_ctrl   = cfg.ctrl_base;
        spin_inc    = {1'b0, spin_reg} + 33'd1;
        poll_to     = spin_inc >= {1'b0, cfg.timeout};
        wait_fin    = cfg.timeout == 32'd0;
        lba_end     = {1'b0, lba_reg} + {40'd0, chunk_reg};
        use48       = lba48_reg && (lba_end > LBA28_LAST);
        range28     = lba_end > LBA28_LIMIT;
        settle_done = settle_reg == 2'd3;
        rem_after   = rem_reg - {23'd0, chunk_reg};
        left_after  = left_reg - 9'd1;
        req_end     = {1'b0, item.lba} + {17'd0, item.count};
        status_b    = b;

        push         = 1'b0;
        desc.script  = SC_NONE;
        desc.sel     = 8'd0;
        desc.chunk   = chunk_reg;
        desc.lba     = lba_reg;
        desc.data    = item.read_data;
        desc.io_base = cfg.io_base;
        desc.tail    = tail_fin(ST_OK);

        if (accept)
        begin
            if (item.mode == MODE_IDENTIFY && phase_reg == PH_IDLE)
            begin
                push        = 1'b1;
                ext_next    = 64'd0;
                desc.script = SC_ID_SEL;
                desc.sel    = SEL_IDENTIFY | slave_bit;
                desc.tail   = tail_rd(port_ctrl, 1'b0);
                phase_next  = PH_ID_SEL_SETTLE;
                settle_next = 2'd0;
            end
            else if (item.mode == MODE_READ && phase_reg == PH_IDLE)
            begin
                push = 1'b1;
                if (!present_reg)
                    desc.tail = tail_fin(ST_NODEV);
                else if (item.count == 32'd0)
                    desc.tail = tail_fin(ST_OK);
                else if ({15'd0, req_end} > cap_reg)
                    desc.tail = tail_fin(ST_RANGE);
                else
                begin
                    lba_next   = item.lba;
                    rem_next   = item.count;
                    chunk_next = (item.count > MAX_CHUNK) ? MAX_CHUNK[8:0] : item.count[8:0];
                    left_next  = chunk_next;
                    spin_next  = 32'd0;
                    phase_next = wait_fin ? PH_IDLE : PH_RD_NB;
                    desc.tail  = wait_fin ? tail_fin(ST_TIMEOUT) : tail_rd(port_status, 1'b0);
                end
            end
            else if (item.mode == MODE_REPLY && phase_reg != PH_IDLE)
            begin
                push = 1'b1;
                unique case (phase_reg)
                    PH_ID_SEL_SETTLE:
                    begin
                        desc.tail   = tail_rd(port_ctrl, 1'b0);
                        settle_next = settle_done ? 2'd0 : settle_reg + 2'd1;
                        if (settle_done)
                        begin
                            desc.script = SC_ID_CMD;
                            phase_next  = PH_ID_CMD_SETTLE;
                        end
                    end
                    PH_ID_CMD_SETTLE:
                    begin
                        settle_next = settle_done ? 2'd0 : settle_reg + 2'd1;
                        if (settle_done)
                        begin
                            phase_next = PH_ID_STATUS;
                            desc.tail  = tail_rd(port_status, 1'b0);
                        end
                        else
                            desc.tail = tail_rd(port_ctrl, 1'b0);
                    end
                    PH_ID_STATUS:
                    begin
                        if (b == 8'd0)
                        begin
                            phase_next = PH_IDLE;
                            desc.tail  = tail_fin(ST_NODEV);
                        end
                        else
                        begin
                            spin_next  = 32'd0;
                            phase_next = wait_fin ? PH_IDLE : PH_ID_NB;
                            desc.tail  = wait_fin ? tail_fin(ST_TIMEOUT)
                                                  : tail_rd(port_status, 1'b0);
                        end
                    end
                    PH_ID_NB, PH_RD_NB:
                    begin
                        if ((b & SR_BSY) != 8'd0)
                        begin
                            spin_next  = spin_inc[31:0];
                            phase_next = poll_to ? PH_IDLE : phase_reg;
                            desc.tail  = poll_to ? tail_fin(ST_TIMEOUT)
                                                 : tail_rd(port_status, 1'b0);
                        end
                        else if (phase_reg == PH_ID_NB)
                        begin
                            phase_next = PH_ID_MID;
                            desc.tail  = tail_rd(cfg.io_base + REG_LBA_MID, 1'b0);
                        end
                        else if (!use48 && range28)
                        begin
                            phase_next = PH_IDLE;
                            desc.tail  = tail_fin(ST_RANGE);
                        end
                        else
                        begin
                            desc.script = SC_RD_SEL;
                            desc.sel    = use48 ? (SEL_LBA48 | slave_bit)
                                                : (SEL_LBA28 | slave_bit
                                                   | {4'd0, lba_reg[27:24]});
                            desc.tail   = tail_rd(port_ctrl, 1'b0);
                            phase_next  = PH_RD_SETTLE;
                            settle_next = 2'd0;
                        end
                    end
                    PH_ID_MID, PH_ID_HI:
                    begin
                        if (b != 8'd0)
                        begin
                            phase_next = PH_IDLE;
                            desc.tail  = tail_fin(ST_NOTATA);
                        end
                        else if (phase_reg == PH_ID_MID)
                        begin
                            phase_next = PH_ID_HI;
                            desc.tail  = tail_rd(cfg.io_base + REG_LBA_HI, 1'b0);
                        end
                        else
                        begin
                            spin_next  = 32'd0;
                            phase_next = wait_fin ? PH_IDLE : PH_ID_DRQ;
                            desc.tail  = wait_fin ? tail_fin(ST_TIMEOUT)
                                                  : tail_rd(port_status, 1'b0);
                        end
                    end
                    PH_ID_DRQ, PH_RD_DRQ:
                    begin
                        if ((status_b & SR_ERR) != 8'd0)
                        begin
                            phase_next = PH_IDLE;
                            desc.tail  = tail_fin(ST_ERR);
                        end
                        else if ((status_b & SR_DF) != 8'd0)
                        begin
                            phase_next = PH_IDLE;
                            desc.tail  = tail_fin(ST_FAULT);
                        end
                        else if ((status_b & SR_BSY) == 8'd0 && (status_b & SR_DRQ) != 8'd0)
                        begin
                            word_next  = 8'd0;
                            phase_next = (phase_reg == PH_ID_DRQ) ? PH_ID_DATA : PH_RD_DATA;
                            desc.tail  = tail_rd(port_data, 1'b1);
                        end
                        else
                        begin
                            spin_next  = spin_inc[31:0];
                            phase_next = poll_to ? PH_IDLE : phase_reg;
                            desc.tail  = poll_to ? tail_fin(ST_TIMEOUT)
                                                 : tail_rd(port_status, 1'b0);
                        end
                    end
                    PH_ID_DATA:
                    begin
                        case (word_reg)
                            8'd60:  cap28_next[15:0]  = item.read_data;
                            8'd61:  cap28_next[31:16] = item.read_data;
                            8'd83:  lba48_next        = item.read_data[10];
                            8'd100: ext_next[15:0]    = ext_reg[15:0] | item.read_data;
                            8'd101: ext_next[31:16]   = ext_reg[31:16] | item.read_data;
                            8'd102: ext_next[47:32]   = ext_reg[47:32] | item.read_data;
                            8'd103: ext_next[63:48]   = ext_reg[63:48] | item.read_data;
                            default: ;
                        endcase
                        if (word_reg == 8'd255)
                        begin
                            cap_next     = (lba48_reg && ext_reg != 64'd0) ? ext_reg
                                                                          : {32'd0, cap28_reg};
                            present_next = 1'b1;
                            phase_next   = PH_IDLE;
                            desc.tail    = tail_fin(ST_OK);
                        end
                        else
                        begin
                            word_next = word_reg + 8'd1;
                            desc.tail = tail_rd(port_data, 1'b1);
                        end
                    end
                    PH_RD_SETTLE:
                    begin
                        settle_next = settle_done ? 2'd0 : settle_reg + 2'd1;
                        if (settle_done)
                        begin
                            desc.script = use48 ? SC_CMD48 : SC_CMD28;
                            spin_next   = 32'd0;
                            phase_next  = wait_fin ? PH_IDLE : PH_RD_DRQ;
                            desc.tail   = wait_fin ? tail_fin(ST_TIMEOUT)
                                                   : tail_rd(port_status, 1'b0);
                        end
                        else
                            desc.tail = tail_rd(port_ctrl, 1'b0);
                    end
                    PH_RD_DATA:
                    begin
                        desc.script = SC_DATA;
                        if (word_reg != 8'd255)
                        begin
                            word_next = word_reg + 8'd1;
                            desc.tail = tail_rd(port_data, 1'b1);
                        end
                        else
                        begin
                            word_next = 8'd0;
                            left_next = left_after;
                            if (left_after != 9'd0 || rem_after != 32'd0)
                            begin
                                // next sector of this chunk, or first of the next chunk
                                if (left_after == 9'd0)
                                begin
                                    lba_next   = lba_end[47:0];
                                    rem_next   = rem_after;
                                    chunk_next = (rem_after > MAX_CHUNK) ? MAX_CHUNK[8:0]
                                                                         : rem_after[8:0];
                                    left_next  = chunk_next;
                                end
                                spin_next  = 32'd0;
                                phase_next = wait_fin ? PH_IDLE
                                           : (left_after != 9'd0) ? PH_RD_DRQ : PH_RD_NB;
                                desc.tail  = wait_fin ? tail_fin(ST_TIMEOUT)
                                                      : tail_rd(port_status, 1'b0);
                            end
                            else
                            begin
                                lba_next   = lba_end[47:0];
                                rem_next   = rem_after;
                                phase_next = PH_IDLE;
                                desc.tail  = tail_fin(ST_OK);
                            end
                        end
                    end
                    default: push = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            spin_reg    <= 32'd0;
            lba_reg     <= 48'd0;
            rem_reg     <= 32'd0;
            chunk_reg   <= 9'd0;
            left_reg    <= 9'd0;
            word_reg    <= 8'd0;
            settle_reg  <= 2'd0;
            present_reg <= 1'b0;
            lba48_reg   <= 1'b0;
            cap28_reg   <= 32'd0;
            cap_reg     <= 64'd0;
            ext_reg     <= 64'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            spin_reg    <= spin_next;
            lba_reg     <= lba_next;
            rem_reg     <= rem_next;
            chunk_reg   <= chunk_next;
            left_reg    <= left_next;
            word_reg    <= word_next;
            settle_reg  <= settle_next;
            present_reg <= present_next;
            lba48_reg   <= lba48_next;
            cap28_reg   <= cap28_next;
            cap_reg     <= cap_next;
            ext_reg     <= ext_next;
        end
    end

endmodule

@@ hw/rtl/aprs_queue.sv @@
// two-entry burst queue between the front and back ends
module aprs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  aprs_pkg::desc_t push_desc,
    input  logic            pop,
    output logic            full,
    output logic            valid,
    output aprs_pkg::desc_t head
);
    import aprs_pkg::*;

    desc_t      slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;

    assign full  = cnt_reg == 2'd2;
    assign valid = cnt_reg != 2'd0;
    assign head  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wptr_reg <= ~wptr_reg;
            if (pop && valid)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push && !full} - {1'b0, pop && valid};
        end
    end

endmodule

@@ hw/rtl/aprs_back.sv @@
// back end: expands one queued burst into result words, one per cycle while rsp_stall is low
module aprs_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  aprs_pkg::desc_t head,
    output logic            pop,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output aprs_pkg::rsp_t  rsp_data
);
    import aprs_pkg::*;

    logic [3:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    rsp_t        out_reg, out_next;
    logic        advance;
    logic        at_tail;
    logic [15:0] off;
    logic [7:0]  val;
    rsp_t        item;

    assign advance   = !valid_reg || !rsp_stall;
    assign at_tail   = idx_reg >= script_len(head.script);
    assign pop       = advance && head_valid && at_tail;
    assign rsp_valid = valid_reg;
    assign rsp_data  = out_reg;

    always_comb
    begin
        off = REG_STATUS;
        val = 8'd0;
        case (head.script)
            SC_ID_SEL, SC_RD_SEL:
            begin
                off = REG_DEVICE;
                val = head.sel;
            end
            SC_ID_CMD:
            begin
                off = (idx_reg < 4'd4) ? REG_COUNT + {14'd0, idx_reg[1:0]} : REG_STATUS;
                val = (idx_reg < 4'd4) ? 8'd0 : CMD_IDENTIFY;
            end
            SC_CMD28:
            begin
                off = (idx_reg < 4'd4) ? REG_COUNT + {14'd0, idx_reg[1:0]} : REG_STATUS;
                case (idx_reg[2:0])
                    3'd0:    val = head.chunk[7:0];
                    3'd1:    val = head.lba[7:0];
                    3'd2:    val = head.lba[15:8];
                    3'd3:    val = head.lba[23:16];
                    default: val = CMD_READ28;
                endcase
            end
            SC_CMD48:
            begin
                // high-order bytes first, then low-order, then the command
                off = (idx_reg < 4'd8) ? REG_COUNT + {14'd0, idx_reg[1:0]} : REG_STATUS;
                case (idx_reg)
                    4'd0:    val = {7'd0, head.chunk[8]};
                    4'd1:    val = head.lba[31:24];
                    4'd2:    val = head.lba[39:32];
                    4'd3:    val = head.lba[47:40];
                    4'd4:    val = head.chunk[7:0];
                    4'd5:    val = head.lba[7:0];
                    4'd6:    val = head.lba[15:8];
                    4'd7:    val = head.lba[23:16];
                    default: val = CMD_READ48;
                endcase
            end
            default: ;
        endcase

        item = '0;
        if (at_tail)
        begin
            item.kind         = head.tail.kind;
            item.port_address = head.tail.port;
            item.access_wide  = head.tail.wide;
            item.status_code  = head.tail.status;
            item.last         = 1'b1;
        end
        else if (head.script == SC_DATA)
        begin
            item.kind      = KIND_DATA;
            item.data_word = head.data;
        end
        else
        begin
            item.kind         = KIND_WRITE;
            item.port_address = head.io_base + off;
            item.write_value  = val;
        end

        idx_next   = idx_reg;
        valid_next = valid_reg;
        out_next   = out_reg;
        if (advance)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                out_next = item;
                idx_next = at_tail ? 4'd0 : idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule
